FILE: rtl/spft_pkg.sv
package spft_pkg;

	localparam logic [7:0] START_BYTE_RST  = 8'd126;
	localparam logic [7:0] ESCAPE_BYTE_RST = 8'd125;
	localparam logic [7:0] FILL_BYTE_RST   = 8'd0;

	localparam int MAX_PAYLOAD_DEF = 256;
	localparam int NUM_LINKS_DEF   = 4;

	localparam int LINK_W   = 2;
	localparam int MAX_BYTES = 11;
	localparam int IDX_W    = $clog2(MAX_BYTES);
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] CMD_HEADER  = 2'd0;
	localparam logic [1:0] CMD_PAYLOAD = 2'd1;
	localparam logic [1:0] CMD_TRAILER = 2'd2;
	localparam logic [1:0] CMD_NONE    = 2'd3;

	localparam logic [1:0] REG_START  = 2'd0;
	localparam logic [1:0] REG_ESCAPE = 2'd1;
	localparam logic [1:0] REG_FILL   = 2'd2;

	typedef enum logic [1:0] {
		KIND_REJECT,
		KIND_HEADER,
		KIND_PAYLOAD,
		KIND_TRAILER
	} kind_t;

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_MID,
		PH_CLOSE
	} phase_t;

	typedef struct packed {
		kind_t                        kind;
		logic [LINK_W-1:0]            link;
		logic [IDX_W-1:0]             last_idx;
		logic [MAX_BYTES-1:0][7:0]    bytes;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} job_slot_t;

endpackage

FILE: rtl/stuffed_packet_framer_tx.sv
// Channel   Direction  Handshake          Payload
// input     in         push / full        cmd, link, header, payload and trailer fields
// result    out        pop / empty        out_byte, out_link, last, frame_end, rejected
// config    in         wr_en (no wait)    wr_index, wr_data
//
// One wire byte leaves per cycle while results are popped: a payload item is 1 byte, or 3 if
// stuffed; a header is 11 to 31, a trailer 4 to 12, a refusal 1. Cmd 3 is taken and dropped.
// The byte sequencer in the back end sets the rate; a 2-entry job queue decouples it from input.
// Reset clears queue, sequencer and output valid flag; config returns to its defaults.
// full rises only when the job queue holds two jobs; a result left unpopped stalls the
// sequencer, and the input once the queue fills.
module stuffed_packet_framer_tx #(
	parameter int MAX_PAYLOAD = spft_pkg::MAX_PAYLOAD_DEF,
	parameter int NUM_LINKS   = spft_pkg::NUM_LINKS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [1:0]                  cmd,
	input  logic [spft_pkg::LINK_W-1:0] link,
	input  logic [7:0]                  pack_type,
	input  logic [7:0]                  dev_num,
	input  logic [7:0]                  session_nr,
	input  logic [31:0]                 sys_time,
	input  logic [15:0]                 payload_size,
	input  logic [7:0]                  header_crc,
	input  logic [7:0]                  data_byte,
	input  logic [15:0]                 payload_crc,
	output logic                        empty,
	input  logic                        pop,
	output logic [7:0]                  out_byte,
	output logic [spft_pkg::LINK_W-1:0] out_link,
	output logic                        last,
	output logic                        frame_end,
	output logic                        rejected,
	input  logic                        wr_en,
	input  logic [1:0]                  wr_index,
	input  logic [7:0]                  wr_data
);

	logic [7:0] start_byte_q;
	logic [7:0] escape_byte_q;
	logic [7:0] fill_byte_q;

	logic                q_push;
	logic                q_pop;
	spft_pkg::job_t      q_wr_job;
	spft_pkg::job_slot_t q_slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q  <= spft_pkg::START_BYTE_RST;
			escape_byte_q <= spft_pkg::ESCAPE_BYTE_RST;
			fill_byte_q   <= spft_pkg::FILL_BYTE_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				spft_pkg::REG_START:  start_byte_q  <= wr_data;
				spft_pkg::REG_ESCAPE: escape_byte_q <= wr_data;
				spft_pkg::REG_FILL:   fill_byte_q   <= wr_data;
				default: ;
			endcase
		end
	end

	spft_front #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.NUM_LINKS   (NUM_LINKS)
	) u_front (
		.push         (push),
		.q_full       (full),
		.cmd          (cmd),
		.link         (link),
		.pack_type    (pack_type),
		.dev_num      (dev_num),
		.session_nr   (session_nr),
		.sys_time     (sys_time),
		.payload_size (payload_size),
		.header_crc   (header_crc),
		.data_byte    (data_byte),
		.payload_crc  (payload_crc),
		.start_byte   (start_byte_q),
		.fill_byte    (fill_byte_q),
		.q_push       (q_push),
		.q_job        (q_wr_job)
	);

	spft_queue #(
		.DEPTH (spft_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_job  (q_wr_job),
		.full    (full),
		.rd_en   (q_pop),
		.rd_slot (q_slot)
	);

	spft_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_slot      (q_slot),
		.q_pop       (q_pop),
		.start_byte  (start_byte_q),
		.escape_byte (escape_byte_q),
		.pop         (pop),
		.empty       (empty),
		.out_byte    (out_byte),
		.out_link    (out_link),
		.last        (last),
		.frame_end   (frame_end),
		.rejected    (rejected)
	);

endmodule

FILE: rtl/spft_front.sv
module spft_front #(
	parameter int MAX_PAYLOAD = spft_pkg::MAX_PAYLOAD_DEF,
	parameter int NUM_LINKS   = spft_pkg::NUM_LINKS_DEF
) (
	input  logic                      push,
	input  logic                      q_full,
	input  logic [1:0]                cmd,
	input  logic [spft_pkg::LINK_W-1:0] link,
	input  logic [7:0]                pack_type,
	input  logic [7:0]                dev_num,
	input  logic [7:0]                session_nr,
	input  logic [31:0]               sys_time,
	input  logic [15:0]               payload_size,
	input  logic [7:0]                header_crc,
	input  logic [7:0]                data_byte,
	input  logic [15:0]               payload_crc,
	input  logic [7:0]                start_byte,
	input  logic [7:0]                fill_byte,
	output logic                      q_push,
	output spft_pkg::job_t            q_job
);

	logic link_bad;
	logic size_bad;

	assign link_bad = {3'b000, link} >= 5'(NUM_LINKS);
	assign size_bad = payload_size > 16'(MAX_PAYLOAD);

	always_comb begin
		q_job       = '0;
		q_job.link  = link;
		q_push      = push && !q_full && (cmd != spft_pkg::CMD_NONE);
		unique case (cmd)
			spft_pkg::CMD_HEADER: begin
				q_job.kind     = spft_pkg::KIND_HEADER;
				q_job.last_idx = spft_pkg::IDX_W'(10);
				q_job.bytes[0]  = start_byte;
				q_job.bytes[1]  = pack_type;
				q_job.bytes[2]  = dev_num;
				q_job.bytes[3]  = session_nr;
				q_job.bytes[4]  = sys_time[31:24];
				q_job.bytes[5]  = sys_time[23:16];
				q_job.bytes[6]  = sys_time[15:8];
				q_job.bytes[7]  = sys_time[7:0];
				q_job.bytes[8]  = payload_size[15:8];
				q_job.bytes[9]  = payload_size[7:0];
				q_job.bytes[10] = header_crc;
			end
			spft_pkg::CMD_PAYLOAD: begin
				q_job.kind     = spft_pkg::KIND_PAYLOAD;
				q_job.bytes[0] = data_byte;
			end
			spft_pkg::CMD_TRAILER: begin
				q_job.kind     = spft_pkg::KIND_TRAILER;
				q_job.last_idx = spft_pkg::IDX_W'(3);
				q_job.bytes[0] = payload_crc[15:8];
				q_job.bytes[1] = payload_crc[7:0];
				q_job.bytes[2] = fill_byte;
				q_job.bytes[3] = fill_byte;
			end
			default: begin
				q_job.kind = spft_pkg::KIND_REJECT;
			end
		endcase
		if (link_bad || (cmd == spft_pkg::CMD_HEADER && size_bad)) begin
			q_job.kind     = spft_pkg::KIND_REJECT;
			q_job.last_idx = '0;
			q_job.bytes    = '0;
		end
	end

endmodule

FILE: rtl/spft_queue.sv
module spft_queue #(
	parameter int DEPTH = spft_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  spft_pkg::job_t      wr_job,
	output logic                full,
	input  logic                rd_en,
	output spft_pkg::job_slot_t rd_slot
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	spft_pkg::job_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full        = count_q == CNT_W'(DEPTH);
	assign do_wr       = wr_en && !full;
	assign do_rd       = rd_en && (count_q != '0);
	assign rd_slot.valid = count_q != '0;
	assign rd_slot.job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

FILE: rtl/spft_back.sv
module spft_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  spft_pkg::job_slot_t         q_slot,
	output logic                        q_pop,
	input  logic [7:0]                  start_byte,
	input  logic [7:0]                  escape_byte,
	input  logic                        pop,
	output logic                        empty,
	output logic [7:0]                  out_byte,
	output logic [spft_pkg::LINK_W-1:0] out_link,
	output logic                        last,
	output logic                        frame_end,
	output logic                        rejected
);

	spft_pkg::phase_t             phase_q;
	spft_pkg::phase_t             phase_d;
	logic [spft_pkg::IDX_W-1:0]   idx_q;
	logic [spft_pkg::IDX_W-1:0]   idx_d;
	logic                         out_valid_q;
	logic [7:0]                   out_byte_q;
	logic [spft_pkg::LINK_W-1:0]  out_link_q;
	logic                         out_last_q;
	logic                         out_frame_end_q;
	logic                         out_rejected_q;

	spft_pkg::job_t job;
	logic [7:0]     cur;
	logic           is_stuff;
	logic           step;
	logic           done;
	logic           res_last;
	logic [7:0]     res_byte;

	assign job  = q_slot.job;
	assign cur  = job.bytes[idx_q];
	assign step = q_slot.valid && (!out_valid_q || pop);
	assign is_stuff = (job.kind != spft_pkg::KIND_REJECT) && (cur == start_byte)
		&& !(job.kind == spft_pkg::KIND_HEADER && idx_q == '0);
	assign res_last = done && (idx_q == job.last_idx);
	assign q_pop    = step && res_last;

	always_comb begin
		phase_d  = phase_q;
		idx_d    = idx_q;
		done     = 1'b0;
		res_byte = cur;
		unique case (phase_q)
			spft_pkg::PH_FIRST: begin
				if (is_stuff) begin
					res_byte = escape_byte;
					phase_d  = spft_pkg::PH_MID;
				end else begin
					done = 1'b1;
				end
			end
			spft_pkg::PH_MID: begin
				phase_d = spft_pkg::PH_CLOSE;
			end
			spft_pkg::PH_CLOSE: begin
				res_byte = escape_byte;
				phase_d  = spft_pkg::PH_FIRST;
				done     = 1'b1;
			end
			default: begin
				phase_d = spft_pkg::PH_FIRST;
			end
		endcase
		if (done) begin
			idx_d = (idx_q == job.last_idx) ? '0 : idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= spft_pkg::PH_FIRST;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q     <= phase_d;
				idx_q       <= idx_d;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_byte_q      <= res_byte;
			out_link_q      <= job.link;
			out_last_q      <= res_last;
			out_frame_end_q <= res_last && (job.kind == spft_pkg::KIND_TRAILER);
			out_rejected_q  <= job.kind == spft_pkg::KIND_REJECT;
		end
	end

	assign empty     = !out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_link  = out_link_q;
	assign last      = out_last_q;
	assign frame_end = out_frame_end_q;
	assign rejected  = out_rejected_q;

	a_rej_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_rejected_q |-> out_last_q)
		else $error("reject without last");
	a_fe_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_frame_end_q |-> out_last_q)
		else $error("frame end without last");
	a_idx_rng: assert property (@(posedge clk) disable iff (!arst_n)
		q_slot.valid |-> idx_q <= job.last_idx)
		else $error("byte index past end of transaction");
	a_mid_held: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != spft_pkg::PH_FIRST |-> q_slot.valid)
		else $error("stuffing sequence without a job");
	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!q_slot.valid |-> idx_q == '0)
		else $error("index not cleared between jobs");

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
	import spft_pkg::*;

	localparam int N_LINKS    = NUM_LINKS_DEF;
	localparam int MAX_PAY    = MAX_PAYLOAD_DEF;
	localparam int DRAIN_GAP  = 40;
	localparam int STALL_MAX  = 4000;
	localparam int N_DIRECTED = 24;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [LINK_W-1:0] link;
		logic [7:0]        pack_type;
		logic [7:0]        dev_num;
		logic [7:0]        session_nr;
		logic [31:0]       sys_time;
		logic [15:0]       payload_size;
		logic [7:0]        header_crc;
		logic [7:0]        data_byte;
		logic [15:0]       payload_crc;
	} pkt_item_t;

	typedef struct packed {
		logic [7:0]        out_byte;
		logic [LINK_W-1:0] out_link;
		logic              last;
		logic              frame_end;
		logic              rejected;
	} wire_byte_t;

	typedef struct {
		bit         is_cfg;
		logic [1:0] reg_idx;
		logic [7:0] reg_val;
		pkt_item_t  it;
		bit         typed;
		wire_byte_t want;
	} dir_row_t;

	logic              clk;
	logic              arst_n;
	logic              push;
	logic              full;
	logic [1:0]        cmd;
	logic [LINK_W-1:0] link;
	logic [7:0]        pack_type;
	logic [7:0]        dev_num;
	logic [7:0]        session_nr;
	logic [31:0]       sys_time;
	logic [15:0]       payload_size;
	logic [7:0]        header_crc;
	logic [7:0]        data_byte;
	logic [15:0]       payload_crc;
	logic              empty;
	logic              pop = 1'b0;
	logic [7:0]        out_byte;
	logic [LINK_W-1:0] out_link;
	logic              last;
	logic              frame_end;
	logic              rejected;
	logic              wr_en;
	logic [1:0]        wr_index;
	logic [7:0]        wr_data;

	wire_byte_t wire_q[$];
	logic [7:0] sh_start;
	logic [7:0] sh_escape;
	logic [7:0] sh_fill;
	int         errors = 0;
	int         snd_idle;
	int         rcv_idle;
	int         stall_cnt = 0;

	stuffed_packet_framer_tx dut (.*);

	dir_row_t dir_tab [N_DIRECTED] = '{
		'{it: '{cmd: CMD_PAYLOAD, link: 2'd0, data_byte: 8'h00, default: '0}, typed: 1'b1,
			want: '{out_byte: 8'h00, out_link: 2'd0, last: 1'b1, default: '0}, default: '0},
		'{it: '{cmd: CMD_PAYLOAD, link: 2'd3, data_byte: 8'hFF, default: '0}, typed: 1'b1,
			want: '{out_byte: 8'hFF, out_link: 2'd3, last: 1'b1, default: '0}, default: '0},
		'{it: '{cmd: CMD_PAYLOAD, link: 2'd1, data_byte: 8'd126, default: '0}, default: '0},
		'{it: '{cmd: CMD_HEADER, link: 2'd0, default: '0}, default: '0},
		'{it: '{cmd: CMD_HEADER, link: 2'd3, pack_type: 8'hFF, dev_num: 8'hFF,
			session_nr: 8'hFF, sys_time: 32'hFFFF_FFFF, payload_size: 16'd256,
			header_crc: 8'hFF, default: '0}, default: '0},
		'{it: '{cmd: CMD_HEADER, link: 2'd2, payload_size: 16'd257, default: '0}, typed: 1'b1,
			want: '{out_link: 2'd2, last: 1'b1, rejected: 1'b1, default: '0}, default: '0},
		'{it: '{cmd: CMD_HEADER, link: 2'd3, payload_size: 16'hFFFF, sys_time: 32'h1234_5678,
			default: '0}, typed: 1'b1,
			want: '{out_link: 2'd3, last: 1'b1, rejected: 1'b1, default: '0}, default: '0},
		'{it: '{cmd: CMD_HEADER, link: 2'd1, pack_type: 8'd126, dev_num: 8'd126,
			session_nr: 8'd126, sys_time: 32'h7E7E_7E7E, payload_size: 16'd126,
			header_crc: 8'd126, default: '0}, default: '0},
		'{it: '{cmd: CMD_TRAILER, link: 2'd0, payload_crc: 16'h0000, default: '0}, default: '0},
		'{it: '{cmd: CMD_TRAILER, link: 2'd3, payload_crc: 16'hFFFF, default: '0}, default: '0},
		'{it: '{cmd: CMD_TRAILER, link: 2'd2, payload_crc: 16'h7E7E, default: '0}, default: '0},
		'{it: '{cmd: CMD_NONE, link: 2'd3, pack_type: 8'hA5, data_byte: 8'h5A,
			payload_crc: 16'hFFFF, default: '0}, default: '0},
		'{is_cfg: 1'b1, reg_idx: REG_START, reg_val: 8'h00, default: '0},
		'{is_cfg: 1'b1, reg_idx: REG_ESCAPE, reg_val: 8'hFF, default: '0},
		'{is_cfg: 1'b1, reg_idx: REG_FILL, reg_val: 8'h00, default: '0},
		'{it: '{cmd: CMD_TRAILER, link: 2'd1, payload_crc: 16'h0000, default: '0}, default: '0},
		'{it: '{cmd: CMD_HEADER, link: 2'd2, default: '0}, default: '0},
		'{it: '{cmd: CMD_PAYLOAD, link: 2'd0, data_byte: 8'h00, default: '0}, default: '0},
		'{is_cfg: 1'b1, reg_idx: REG_START, reg_val: 8'hFF, default: '0},
		'{is_cfg: 1'b1, reg_idx: REG_ESCAPE, reg_val: 8'h00, default: '0},
		'{is_cfg: 1'b1, reg_idx: REG_FILL, reg_val: 8'hFF, default: '0},
		'{it: '{cmd: CMD_TRAILER, link: 2'd3, payload_crc: 16'hFF00, default: '0}, default: '0},
		'{it: '{cmd: CMD_PAYLOAD, link: 2'd2, data_byte: 8'hFF, default: '0}, default: '0},
		'{it: '{cmd: CMD_HEADER, link: 2'd1, pack_type: 8'hFF, dev_num: 8'h00,
			session_nr: 8'hFF, sys_time: 32'hFF00_FF00, payload_size: 16'h00FF,
			header_crc: 8'hFF, default: '0}, default: '0}
	};

	function automatic void put_raw(input logic [7:0] b, input logic [LINK_W-1:0] lk);
		wire_q.push_back(wire_byte_t'{out_byte: b, out_link: lk, default: '0});
	endfunction

	function automatic void put_stuffed(input logic [7:0] b, input logic [LINK_W-1:0] lk);
		if (b == sh_start) begin
			put_raw(sh_escape, lk);
			put_raw(b, lk);
			put_raw(sh_escape, lk);
		end else begin
			put_raw(b, lk);
		end
	endfunction

	function automatic void frame_item(input pkt_item_t it);
		if (it.cmd == CMD_NONE)
			return;
		if (int'(it.link) >= N_LINKS ||
			(it.cmd == CMD_HEADER && it.payload_size > MAX_PAY)) begin
			wire_q.push_back(wire_byte_t'{out_byte: 8'h00, out_link: it.link, last: 1'b1,
				frame_end: 1'b0, rejected: 1'b1});
			return;
		end
		case (it.cmd)
			CMD_HEADER: begin
				put_raw(sh_start, it.link);
				put_stuffed(it.pack_type, it.link);
				put_stuffed(it.dev_num, it.link);
				put_stuffed(it.session_nr, it.link);
				put_stuffed(it.sys_time[31:24], it.link);
				put_stuffed(it.sys_time[23:16], it.link);
				put_stuffed(it.sys_time[15:8], it.link);
				put_stuffed(it.sys_time[7:0], it.link);
				put_stuffed(it.payload_size[15:8], it.link);
				put_stuffed(it.payload_size[7:0], it.link);
				put_stuffed(it.header_crc, it.link);
			end
			CMD_PAYLOAD: put_stuffed(it.data_byte, it.link);
			default: begin
				put_stuffed(it.payload_crc[15:8], it.link);
				put_stuffed(it.payload_crc[7:0], it.link);
				put_stuffed(sh_fill, it.link);
				put_stuffed(sh_fill, it.link);
				wire_q[wire_q.size()-1].frame_end = 1'b1;
			end
		endcase
		wire_q[wire_q.size()-1].last = 1'b1;
	endfunction

	function automatic void flag_mismatch(input string what, input wire_byte_t want,
		input wire_byte_t got);
		errors++;
		if (errors <= 10)
			$display("mismatch (%s): got %02h/%0d/%b%b%b want %02h/%0d/%b%b%b",
				what, got.out_byte, got.out_link, got.last, got.frame_end, got.rejected,
				want.out_byte, want.out_link, want.last, want.frame_end, want.rejected);
	endfunction

	// mostly random, one in four hits the start value to force stuffing
	function automatic logic [7:0] pick_byte();
		return ($urandom_range(0, 3) == 0) ? sh_start : 8'($urandom);
	endfunction

	function automatic pkt_item_t noise_item();
		pkt_item_t it;
		it.cmd          = 2'($urandom);
		it.link         = LINK_W'($urandom);
		it.pack_type    = 8'($urandom);
		it.dev_num      = 8'($urandom);
		it.session_nr   = 8'($urandom);
		it.sys_time     = $urandom;
		it.payload_size = 16'($urandom);
		it.header_crc   = 8'($urandom);
		it.data_byte    = 8'($urandom);
		it.payload_crc  = 16'($urandom);
		return it;
	endfunction

	task automatic drive_item(input pkt_item_t it, input bit typed, input wire_byte_t want);
		while ($urandom_range(0, 99) < snd_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push         <= 1'b1;
		cmd          <= it.cmd;
		link         <= it.link;
		pack_type    <= it.pack_type;
		dev_num      <= it.dev_num;
		session_nr   <= it.session_nr;
		sys_time     <= it.sys_time;
		payload_size <= it.payload_size;
		header_crc   <= it.header_crc;
		data_byte    <= it.data_byte;
		payload_crc  <= it.payload_crc;
		do @(posedge clk); while (full);
		if (typed)
			wire_q.push_back(want);
		else
			frame_item(it);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (wire_q.size() != 0)
			@(posedge clk);
		// idle gap before a register write
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [7:0] val);
		drain();
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_START:  sh_start  = val;
			REG_ESCAPE: sh_escape = val;
			REG_FILL:   sh_fill   = val;
			default: ;
		endcase
	endtask

	task automatic run_traffic(input int n_items);
		pkt_item_t          it;
		logic [LINK_W-1:0]  lk;
		int                 sent;
		int                 n_pay;
		int                 sel;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 99) < 80) begin
				lk = LINK_W'($urandom);
				it = noise_item();
				it.cmd        = CMD_HEADER;
				it.link       = lk;
				it.pack_type  = pick_byte();
				it.dev_num    = pick_byte();
				it.session_nr = pick_byte();
				it.sys_time   = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
				it.header_crc = pick_byte();
				sel = $urandom_range(0, 19);
				if (sel == 0)
					it.payload_size = 16'($urandom_range(MAX_PAY + 1, 65535));
				else if (sel == 1)
					it.payload_size = 16'($urandom_range(6, MAX_PAY));
				else if (sel == 2)
					it.payload_size = 16'($urandom);
				else
					it.payload_size = 16'($urandom_range(0, 5));
				// long payloads are truncated to keep the run short
				n_pay = (it.payload_size > 6) ? $urandom_range(0, 6) : int'(it.payload_size);
				drive_item(it, 1'b0, '0);
				repeat (n_pay) begin
					it = noise_item();
					it.cmd       = CMD_PAYLOAD;
					it.link      = lk;
					it.data_byte = pick_byte();
					drive_item(it, 1'b0, '0);
				end
				sent += 1 + n_pay;
				if ($urandom_range(0, 9) != 0) begin
					it = noise_item();
					it.cmd         = CMD_TRAILER;
					it.link        = lk;
					it.payload_crc = {pick_byte(), pick_byte()};
					drive_item(it, 1'b0, '0);
					sent++;
				end
			end else begin
				it = noise_item();
				drive_item(it, 1'b0, '0);
				if (it.cmd != CMD_NONE)
					sent++;
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		wire_byte_t got;
		wire_byte_t want;
		if (arst_n && pop && !empty) begin
			got = '{out_byte, out_link, last, frame_end, rejected};
			if (wire_q.size() == 0) begin
				flag_mismatch("unexpected transaction", '0, got);
			end else begin
				want = wire_q.pop_front();
				if (got.out_byte !== want.out_byte || got.out_link !== want.out_link ||
					got.last !== want.last || got.frame_end !== want.frame_end ||
					got.rejected !== want.rejected)
					flag_mismatch("field", want, got);
			end
		end
		pop <= ($urandom_range(0, 99) >= rcv_idle);
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || wr_en) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_MAX) begin
			$display("watchdog: no transaction for %0d cycles", STALL_MAX);
			$display("*** FAILED ***");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	initial begin
		arst_n       = 1'b0;
		push         = 1'b0;
		cmd          = CMD_NONE;
		link         = '0;
		pack_type    = '0;
		dev_num      = '0;
		session_nr   = '0;
		sys_time     = '0;
		payload_size = '0;
		header_crc   = '0;
		data_byte    = '0;
		payload_crc  = '0;
		wr_en        = 1'b0;
		wr_index     = REG_START;
		wr_data      = '0;
		sh_start     = START_BYTE_RST;
		sh_escape    = ESCAPE_BYTE_RST;
		sh_fill      = FILL_BYTE_RST;
		snd_idle     = 38;
		rcv_idle     = 50;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg)
				set_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
			else
				drive_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);
		end

		// start == fill, both at the low extreme
		set_reg(REG_START, 8'h00);
		set_reg(REG_ESCAPE, 8'hFF);
		set_reg(REG_FILL, 8'h00);
		run_traffic(70);

		snd_idle = 50;
		rcv_idle = 38;
		set_reg(REG_START, 8'hFF);
		set_reg(REG_ESCAPE, 8'h00);
		set_reg(REG_FILL, 8'h5A);
		run_traffic(70);

		snd_idle = 0;
		rcv_idle = 0;
		set_reg(REG_START, 8'($urandom));
		set_reg(REG_ESCAPE, 8'($urandom));
		set_reg(REG_FILL, ($urandom_range(0, 1) == 0) ? sh_start : 8'($urandom));
		run_traffic(70);

		drain();
		if (errors == 0 && wire_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
